>>> sv/lz78_variable_width_encoder_defines.svh
// Assertion macros shared by the encoder modules.
`ifndef LZ78_VARIABLE_WIDTH_ENCODER_DEFINES_SVH
`define LZ78_VARIABLE_WIDTH_ENCODER_DEFINES_SVH

// Check a property on every clock outside reset.
`define LZVW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock, reset included.
`define LZVW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> sv/lzvw_pkg.sv
// Shared types and constants of the LZ78 encoder.
package lzvw_pkg;

  localparam int unsigned VAL_W  = 24;  // holds the widest code plus one byte
  localparam int unsigned NB_W   = 5;
  localparam int unsigned BUF_W  = 32;
  localparam int unsigned FILL_W = 6;

  localparam logic [7:0] ASCII_ZERO = 8'h30;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [NB_W-1:0]  nbits;
    logic             flush;
  } cmd_t;

endpackage

>>> sv/lzvw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lzvw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/lzvw_cmd_fifo.sv
// Two-entry queue of packing commands between dictionary and packer.
module lzvw_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lzvw_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output lzvw_pkg::cmd_t cmd_o
);
  import lzvw_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> sv/lzvw_dict.sv
// Front end: accepts bytes, looks up phrases in the hashed dictionary, issues pack commands.
`include "lz78_variable_width_encoder_defines.svh"
module lzvw_dict #(
  parameter int unsigned DICT_ENTRIES  = 4096,
  parameter int unsigned MAX_CODE_BITS = 12
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     data_byte_i,
  input  logic           last_byte_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output lzvw_pkg::cmd_t cmd_o,
  output logic           cmd_push_o,
  input  logic           cmd_full_i
);
  import lzvw_pkg::*;

  localparam int unsigned M      = MAX_CODE_BITS;
  localparam int unsigned SB     = $clog2(DICT_ENTRIES) + 1;
  localparam int unsigned DEPTH  = 1 << SB;
  localparam int unsigned KEY_W  = M + 8;
  localparam int unsigned ENT_W  = 1 + KEY_W + M;
  localparam int unsigned CW_W   = $clog2(M + 1);
  localparam int unsigned NCHUNK = (KEY_W + SB - 1) / SB;
  localparam int unsigned LIM_A  = (1 << M) - 1;
  localparam int unsigned LIM_B  = DICT_ENTRIES - 1;
  localparam logic [M-1:0] CODE_LIMIT = M'((LIM_A < LIM_B) ? LIM_A : LIM_B);

  typedef enum logic [2:0] {
    D_CLEAR = 3'b001,
    D_IDLE  = 3'b010,
    D_LOOK  = 3'b100
  } dstate_e;

  dstate_e           state_q, state_d;
  logic [SB-1:0]     clr_q, clr_d, slot_q, slot_d;
  logic [7:0]        byte_q, byte_d;
  logic              last_q, last_d;
  logic [M-1:0]      phrase_q, phrase_d, count_q, count_d, wc_q, wc_d;
  logic [CW_W-1:0]   cw_q, cw_d;

  logic              we;
  logic [SB-1:0]     waddr;
  logic [ENT_W-1:0]  wdata, rdata;
  logic              r_valid, hit, need_cmd, resolve, go, accept, do_insert;
  logic [KEY_W-1:0]  r_key, key_q, key_in;
  logic [M-1:0]      r_code, bound, count_inc;

  function automatic logic [SB-1:0] hash_f(input logic [KEY_W-1:0] k);
    logic [NCHUNK*SB-1:0] ext;
    logic [SB-1:0]        h;
    ext = (NCHUNK*SB)'(k);
    h   = '0;
    for (int i = 0; i < NCHUNK; i++) begin
      h = h ^ ext[i*SB +: SB];
    end
    return h;
  endfunction

  assign r_valid = rdata[ENT_W-1];
  assign r_key   = rdata[ENT_W-2 -: KEY_W];
  assign r_code  = rdata[M-1:0];
  assign key_q   = {phrase_q, byte_q};
  assign key_in  = {phrase_q, data_byte_i};

  assign in_ready_o = (state_q == D_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign hit        = r_valid && (r_key == key_q);
  assign need_cmd   = !hit || last_q;
  assign resolve    = (state_q == D_LOOK) && (!r_valid || hit);
  assign go         = resolve && !(need_cmd && cmd_full_i);
  assign do_insert  = go && !hit && (count_q < CODE_LIMIT);
  assign count_inc  = count_q + M'(1);
  assign bound      = (cw_q == '0) ? '0 : (M'(1) << (cw_q - CW_W'(1)));

  assign cmd_push_o   = go && need_cmd;
  assign cmd_o.value  = hit ? VAL_W'(r_code) : VAL_W'(key_q);
  assign cmd_o.nbits  = hit ? NB_W'(cw_q) : (NB_W'(cw_q) + NB_W'(8));
  assign cmd_o.flush  = last_q;

  assign we    = (state_q == D_CLEAR) || do_insert;
  assign waddr = (state_q == D_CLEAR) ? clr_q : slot_q;
  assign wdata = (state_q == D_CLEAR) ? '0 : {1'b1, key_q, count_inc};

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    slot_d   = slot_q;
    byte_d   = byte_q;
    last_d   = last_q;
    phrase_d = phrase_q;
    count_d  = count_q;
    cw_d     = cw_q;
    wc_d     = wc_q;
    unique case (state_q)
      D_CLEAR: begin
        clr_d = clr_q + SB'(1);
        if (&clr_q) state_d = D_IDLE;
      end
      D_IDLE: begin
        if (accept) begin
          byte_d  = data_byte_i;
          last_d  = last_byte_i;
          slot_d  = hash_f(key_in);
          state_d = D_LOOK;
        end
      end
      D_LOOK: begin
        if (r_valid && !hit) begin
          // probe the next slot
          slot_d = slot_q + SB'(1);
        end else if (go) begin
          if (hit) begin
            phrase_d = r_code;
          end else begin
            phrase_d = '0;
            if (do_insert) begin
              count_d = count_inc;
              if (wc_q == bound) begin
                cw_d = cw_q + CW_W'(1);
                wc_d = M'(1);
              end else begin
                wc_d = wc_q + M'(1);
              end
            end
          end
          if (last_q) begin
            // end of stream: restart with an empty dictionary
            phrase_d = '0;
            count_d  = '0;
            cw_d     = '0;
            wc_d     = '0;
            clr_d    = '0;
            state_d  = D_CLEAR;
          end else begin
            state_d = D_IDLE;
          end
        end
      end
      default: state_d = D_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= D_CLEAR;
      clr_q    <= '0;
      phrase_q <= '0;
      count_q  <= '0;
      cw_q     <= '0;
      wc_q     <= '0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      phrase_q <= phrase_d;
      count_q  <= count_d;
      cw_q     <= cw_d;
      wc_q     <= wc_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    byte_q <= byte_d;
  end

  lzvw_ram #(
    .WIDTH(ENT_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(slot_d),
    .rdata_o(rdata)
  );

  `LZVW_ASSERT(a_count_limit, count_q <= CODE_LIMIT, "entry count beyond limit")
  `LZVW_ASSERT(a_width_limit, cw_q <= CW_W'(M), "code width beyond maximum")
  `LZVW_ASSERT(a_push_look, cmd_push_o |-> (state_q == D_LOOK) && !cmd_full_i, "bad push")

endmodule

>>> sv/lzvw_pack.sv
// Back end: packs command bits into bytes and sends the tail byte and bit-count digit.
`include "lz78_variable_width_encoder_defines.svh"
module lzvw_pack (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lzvw_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  output logic [7:0]     out_byte_o,
  output logic           end_of_stream_o,
  output logic           out_valid_o,
  input  logic           out_ready_i
);
  import lzvw_pkg::*;

  typedef enum logic [3:0] {
    P_IDLE  = 4'b0001,
    P_DRAIN = 4'b0010,
    P_TAIL  = 4'b0100,
    P_DIGIT = 4'b1000
  } pstate_e;

  pstate_e           state_q, state_d;
  logic [BUF_W-1:0]  buf_q, buf_d;
  logic [FILL_W-1:0] fill_q, fill_d, fill_less;
  logic              flush_q, flush_d;
  logic              out_valid_q, out_valid_d, eos_q, eos_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic              can_emit;
  logic [BUF_W-1:0]  mask_less, mask_fill, top_shift;

  assign can_emit   = !out_valid_q || out_ready_i;
  assign fill_less  = fill_q - FILL_W'(8);
  assign mask_less  = ~({BUF_W{1'b1}} << fill_less);
  assign mask_fill  = ~({BUF_W{1'b1}} << fill_q);
  assign top_shift  = buf_q >> fill_less;
  assign cmd_pop_o  = (state_q == P_IDLE) && cmd_valid_i;

  always_comb begin
    state_d     = state_q;
    buf_d       = buf_q;
    fill_d      = fill_q;
    flush_d     = flush_q;
    out_byte_d  = out_byte_q;
    eos_d       = eos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      P_IDLE: begin
        if (cmd_valid_i) begin
          buf_d   = (buf_q << cmd_i.nbits) | BUF_W'(cmd_i.value);
          fill_d  = fill_q + FILL_W'(cmd_i.nbits);
          flush_d = cmd_i.flush;
          state_d = P_DRAIN;
        end
      end
      P_DRAIN: begin
        if (fill_q > FILL_W'(8)) begin
          if (can_emit) begin
            out_byte_d  = top_shift[7:0];
            eos_d       = 1'b0;
            out_valid_d = 1'b1;
            fill_d      = fill_less;
            buf_d       = buf_q & mask_less;
          end
        end else begin
          state_d = flush_q ? P_TAIL : P_IDLE;
        end
      end
      P_TAIL: begin
        if (can_emit) begin
          out_byte_d  = 8'(buf_q & mask_fill);
          eos_d       = 1'b0;
          out_valid_d = 1'b1;
          state_d     = P_DIGIT;
        end
      end
      P_DIGIT: begin
        if (can_emit) begin
          out_byte_d  = ASCII_ZERO + 8'(fill_q);
          eos_d       = 1'b1;
          out_valid_d = 1'b1;
          buf_d       = '0;
          fill_d      = '0;
          flush_d     = 1'b0;
          state_d     = P_IDLE;
        end
      end
      default: state_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= P_IDLE;
      buf_q       <= '0;
      fill_q      <= '0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      buf_q       <= buf_d;
      fill_q      <= fill_d;
      flush_q     <= flush_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    eos_q      <= eos_d;
  end

  assign out_byte_o      = out_byte_q;
  assign end_of_stream_o = eos_q;
  assign out_valid_o     = out_valid_q;

  `LZVW_ASSERT(a_idle_fill, (state_q == P_IDLE) |-> fill_q <= FILL_W'(8), "idle with full byte")
  `LZVW_ASSERT(a_digit_range, (out_valid_o && end_of_stream_o) |-> out_byte_o <= ASCII_ZERO + 8'd8, "bad digit")

endmodule

>>> sv/lz78_variable_width_encoder.sv
// LZ78 encoder with growing code width. Each byte item is accepted and then probes the
// hashed phrase table slot by slot (one probe in the usual case); no new item is accepted
// until the last one is resolved. The packer behind a two-entry command queue sends one
// output byte per cycle while the output is ready, so long output bursts can set the pace.
// After reset and after every item flagged as last, a clearing pass writes every slot of
// the phrase table, 2^(clog2(DICT_ENTRIES)+1) slots (8192 at the defaults), during which
// no item is accepted.
module lz78_variable_width_encoder #(
  parameter int unsigned DICT_ENTRIES  = 4096,
  parameter int unsigned MAX_CODE_BITS = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic [7:0] out_byte_o,
  output logic       end_of_stream_o,
  output logic       out_valid_o,
  input  logic       out_ready_i
);
  import lzvw_pkg::*;

  cmd_t push_cmd, pop_cmd;
  logic push, full, pop, pend;

  lzvw_dict #(
    .DICT_ENTRIES (DICT_ENTRIES),
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_dict (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .data_byte_i(data_byte_i),
    .last_byte_i(last_byte_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (push_cmd),
    .cmd_push_o (push),
    .cmd_full_i (full)
  );

  lzvw_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(pend),
    .cmd_o  (pop_cmd)
  );

  lzvw_pack u_pack (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (pop_cmd),
    .cmd_valid_i    (pend),
    .cmd_pop_o      (pop),
    .out_byte_o     (out_byte_o),
    .end_of_stream_o(end_of_stream_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i)
  );

endmodule
